[hdl/gpc_pkg.sv]
package gpc_pkg;

    localparam int PHASE_BITS_DEF       = 16;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIT_FREQ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_C    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STAND_THR   = 3'd5;

    localparam logic [15:0] DUTY_MIN   = 16'd7;
    localparam logic [15:0] DUTY_MAX   = 16'd65529;
    localparam logic [15:0] CLOCK_ONE  = 16'd16384;

    // sin(pi/2 * num / depth) in Q1.14, num in [0, depth]; evaluated at elaboration
    // or as a constant table lookup
    function automatic logic [15:0] quarter_sine(input int unsigned num, input int unsigned depth);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (64'd1686629713 * 64'(num)) / 64'(depth);
        x2 = (x * x) >> 30;
        t  = (64'd1 << 30) - x2 / 64'd72;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + 64'd32768) >> 16;
        if (s > 64'd16384) begin
            s = 64'd16384;
        end
        return s[15:0];
    endfunction

endpackage

[hdl/gpc_warp_div.sv]
// Bit-serial restoring divider for the duty warp: one quotient bit per cycle.
// q = floor(num * 2^31 / den), num < den, 32 quotient bits (top bit always 0)
module gpc_warp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    import gpc_pkg::*;

    logic [33:0] r_rem;
    logic [33:0] n_rem;
    logic [32:0] r_den;
    logic [31:0] r_quot;
    logic [31:0] n_quot;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [34:0] w_trial;

    // one restoring step: shift, try subtract
    always_comb begin
        w_trial = {r_rem, 1'b0} - {2'b00, r_den};
        if (!w_trial[34]) begin
            n_rem  = w_trial[33:0];
            n_quot = {r_quot[30:0], 1'b1};
        end else begin
            n_rem  = {r_rem[32:0], 1'b0};
            n_quot = {r_quot[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'd30) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[hdl/gait_phase_clock_top.sv]
// Channel  | Dir | tdata fields (low bit up)                            | tuser
// s_axis   | in  | time_step, forward, lateral, turn (64 bits)          | -
// m_axis   | out | leg_clock_0, leg_clock_1, leg_clock_2, leg_clock_3   | standing
// cfg      | in  | i_cfg_we / i_cfg_idx / i_cfg_data, no read-back       | -
//
// One item at a time. The phase step multiply is shift-add, one bit of time_step a
// cycle, followed by the phase update. Each walking leg runs the shared bit-serial
// warp divider: start, 31 quotient bits, store. A result is loaded after the phase
// update when standing, after all four leg divisions when walking; the input is
// ready again on the next cycle. A stalled result waits in the output
// register while the next item is computed; that item then holds in ST_OUT.
// Reset is synchronous active low and restores config registers, state and phase.
module gait_phase_clock_top #(
    parameter int PHASE_BITS       = gpc_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = gpc_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,  // time_step, fwd, lat, turn
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,  // leg_clock_0..3
    output logic                          m_axis_tuser,  // standing
    input  logic                          i_cfg_we,
    input  logic [gpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gpc_pkg::*;

    localparam int TW = $clog2(SINE_TABLE_DEPTH);
    localparam int QW = SINE_TABLE_DEPTH / 4;
    localparam logic [TW-2:0] J_TOP = (TW-1)'(QW);
    localparam logic [15:0] QTOP = quarter_sine(SINE_TABLE_DEPTH, SINE_TABLE_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIVS = 5'b00100,
        ST_DIVW = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state r_state;

    logic [15:0] r_freq, r_off_a, r_off_b, r_off_c, r_duty;
    logic [14:0] r_thr;
    logic [PHASE_BITS-1:0] r_phase;

    logic [15:0] r_ts;
    logic [31:0] r_prod;
    logic [4:0]  r_bit;
    logic        r_stand;
    logic [1:0]  r_leg;
    logic [15:0] r_clk [4];
    logic        r_ovalid;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq  <= 16'd8192;
            r_off_a <= 16'd32768;
            r_off_b <= '0;
            r_off_c <= '0;
            r_duty  <= 16'd32768;
            r_thr   <= 15'd819;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GAIT_FREQ: r_freq  <= i_cfg_data;
                REG_OFFSET_A:  r_off_a <= i_cfg_data;
                REG_OFFSET_B:  r_off_b <= i_cfg_data;
                REG_OFFSET_C:  r_off_c <= i_cfg_data;
                REG_DUTY:      r_duty  <= i_cfg_data;
                REG_STAND_THR: r_thr   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // standing test on command magnitudes
    function automatic logic below(input logic [15:0] v, input logic [14:0] thr);
        logic [15:0] mag;
        mag = v[15] ? (16'd0 - v) : v;
        return mag < {1'b0, thr};
    endfunction

    logic w_stand;
    assign w_stand = below(s_axis_tdata[31:16], r_thr) && below(s_axis_tdata[47:32], r_thr)
                     && below(s_axis_tdata[63:48], r_thr);

    // phase step from Q4.28 product
    logic [PHASE_BITS-1:0] w_step;
    always_comb begin
        if (PHASE_BITS <= 28) begin
            w_step = PHASE_BITS'(r_prod >> (28 - PHASE_BITS));
        end else begin
            w_step = PHASE_BITS'({4'd0, r_prod[27:0]}) << (PHASE_BITS - 28);
        end
    end

    // leg offsets in Q0.PHASE_BITS
    function automatic logic [PHASE_BITS-1:0] rs(input logic [15:0] v);
        if (PHASE_BITS >= 16) begin
            return PHASE_BITS'(v) << (PHASE_BITS - 16);
        end else begin
            return PHASE_BITS'(v >> (16 - PHASE_BITS));
        end
    endfunction

    logic [PHASE_BITS-1:0] w_lp;
    always_comb begin
        case (r_leg)
            2'd0:    w_lp = r_phase + rs(r_off_a) + rs(r_off_b) + rs(r_off_c);
            2'd1:    w_lp = r_phase + rs(r_off_b);
            2'd2:    w_lp = r_phase + rs(r_off_c);
            default: w_lp = r_phase + rs(r_off_a);
        endcase
    end

    // leg phase to Q0.32, compare with clamped duty
    logic [31:0] w_p32, w_d32;
    logic [15:0] w_duty;
    logic        w_stance;
    always_comb begin
        w_duty = (r_duty < DUTY_MIN) ? DUTY_MIN : ((r_duty > DUTY_MAX) ? DUTY_MAX : r_duty);
        w_d32  = {w_duty, 16'd0};
        if (PHASE_BITS >= 32) begin
            w_p32 = w_lp[PHASE_BITS-1 -: 32];
        end else begin
            w_p32 = 32'(w_lp) << (32 - PHASE_BITS);
        end
        w_stance = w_p32 < w_d32;
    end

    logic        r_swing;
    logic        w_dstart, w_ddone;
    logic [31:0] w_quot;
    assign w_dstart = (r_state == ST_DIVS);

    gpc_warp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_stance ? {1'b0, w_p32} : {1'b0, w_p32 - w_d32}),
        .i_den   (w_stance ? {1'b0, w_d32} : (33'h1_0000_0000 - {1'b0, w_d32})),
        .o_done  (w_ddone),
        .o_quot  (w_quot)
    );

    // constant quarter-wave table, one entry per step of four in the quarter
    logic [15:0] w_qtab [QW];
    for (genvar g = 0; g < QW; g++) begin : g_qtab
        localparam logic [15:0] QV = quarter_sine(4 * g, SINE_TABLE_DEPTH);
        assign w_qtab[g] = QV;
    end

    // table index and quadrant, magnitude from the quarter-wave table
    logic [31:0]   w_w;
    logic [TW-1:0] w_idx;
    logic [1:0]    w_quad;
    logic [TW-3:0] w_rq;
    logic [TW-2:0] w_j;
    logic [15:0]   w_mag, w_clk;
    always_comb begin
        w_w    = r_swing ? (32'h8000_0000 + w_quot) : w_quot;
        w_idx  = w_w[31 -: TW];
        w_quad = w_idx[TW-1 -: 2];
        w_rq   = w_idx[TW-3:0];
        if (w_quad[0]) begin
            w_j = J_TOP - {1'b0, w_rq};
        end else begin
            w_j = {1'b0, w_rq};
        end
        w_mag = (w_j == J_TOP) ? QTOP : w_qtab[w_j[TW-3:0]];
        w_clk = w_quad[1] ? (16'd0 - w_mag) : w_mag;
    end

    // output register load
    logic w_load;
    assign w_load = (r_state == ST_OUT) && (!r_ovalid || m_axis_tready);

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_ts    <= s_axis_tdata[15:0];
                        r_prod  <= '0;
                        r_bit   <= '0;
                        r_stand <= w_stand;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // shift-add, MSB of time_step first
                    if (r_bit == 5'd16) begin
                        r_phase <= r_phase + w_step;
                        r_leg   <= 2'd0;
                        r_state <= r_stand ? ST_OUT : ST_DIVS;
                    end else begin
                        r_prod <= {r_prod[30:0], 1'b0} + (r_ts[15] ? {16'd0, r_freq} : 32'd0);
                        r_ts   <= {r_ts[14:0], 1'b0};
                        r_bit  <= r_bit + 5'd1;
                    end
                end
                ST_DIVS: begin
                    r_swing <= !w_stance;
                    r_state <= ST_DIVW;
                end
                ST_DIVW: begin
                    if (w_ddone) begin
                        r_clk[r_leg] <= w_clk;
                        r_leg <= r_leg + 2'd1;
                        r_state <= (r_leg == 2'd3) ? ST_OUT : ST_DIVS;
                    end
                end
                ST_OUT: begin
                    if (w_load) begin
                        m_axis_tuser <= r_stand;
                        m_axis_tdata <= r_stand ? {4{CLOCK_ONE}}
                                        : {r_clk[3], r_clk[2], r_clk[1], r_clk[0]};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;

endmodule
